// ===== hdl/bfasa_pkg.sv =====
// Shared types and constants of the best-fit aligned segment allocator.
`default_nettype none

package bfasa_pkg;

   localparam int ADDR_W     = 35;
   localparam int ALIGN_W    = 13;
   // Remainder unit: four dividend bits per cycle over a zero-padded 36-bit word.
   localparam int DIV_BITS   = 4;
   localparam int DIV_W      = 36;
   localparam int DIV_STEPS  = DIV_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [ADDR_W-1:0] POOL_RESET  = 35'd17179869184;
   localparam logic [ALIGN_W-1:0] ALIGN_RESET = 13'd1;
   localparam logic [ADDR_W-1:0] POOL_BASE   = 35'd1;

   typedef enum logic [1:0] {
      ACT_ALLOC = 2'd0,
      ACT_FREE  = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      RS_OK       = 2'd0,
      RS_NOFIT    = 2'd1,
      RS_NOTALLOC = 2'd2,
      RS_FULL     = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_POOL  = 1'b0,
      CSR_ALIGN = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type        action;
      logic [ADDR_W-1:0] request_size;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] granted_address;
      logic              is_allocated;
   } rsp_type;

   // One row of the segment table
   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] length;
      logic              used;
   } entry_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_INIT,
      DP_LOAD,
      DP_READ,
      DP_NEXT,
      DP_DIV_START,
      DP_DIV_STEP,
      DP_EVAL,
      DP_MATCH,
      DP_PLAN_ALLOC,
      DP_PLAN_FREE,
      DP_SH_READ,
      DP_SH_WRITE,
      DP_WR_SKIP,
      DP_WR_USED,
      DP_WR_REM,
      DP_WR_MERGE,
      DP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type code;
      logic       hit;
      logic       grant;
      logic       commit;
   } dp_cmd_type;

   typedef struct packed {
      action_type act;
      logic       size_zero;
      logic       idx_end;
      logic       cur_used;
      logic       cur_match;
      logic       div_busy;
      logic       best_valid;
      logic       need_over;
      logic       has_skip;
      logic       has_rem;
      logic       sh_done;
      logic       pool_wr;
   } dp_stat_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_LOOK,
      ST_DIV,
      ST_SCAN_END,
      ST_FREE_RD,
      ST_FREE_PLAN,
      ST_FREE_WR,
      ST_SH_RD,
      ST_SH_WR,
      ST_WR_SKIP,
      ST_WR_USED,
      ST_WR_REM,
      ST_ALLOC_DONE
   } fsm_state_type;

endpackage

`default_nettype wire

// ===== hdl/best_fit_aligned_segment_allocator.sv =====
// Top level of the best-fit aligned segment allocator.
//
//   channel   handshake                    payload
//   request   start / busy                 req_data  (req_type)
//   response  rsp_valid (one-cycle strobe) rsp_data  (rsp_type)
//   csr       csr_valid / csr_ready        csr_index, csr_data
//
// One request at a time. Allocate walks every table row, running the 4-bit-per-cycle
// remainder unit on each free row, then moves the rows above the best one up and
// writes up to three rows; free and query walk the rows until a match, and a free
// then writes the merged row and moves the rows behind it down.
// A pool_size write and reset each rebuild the first row while busy;
// csr writes wait while start is high. Responses cannot be stalled.
`default_nettype none

module best_fit_aligned_segment_allocator #(
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire bfasa_pkg::req_type           req_data,
   output logic                              rsp_valid,
   output bfasa_pkg::rsp_type                rsp_data,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire bfasa_pkg::csr_index_type     csr_index,
   input  wire logic [bfasa_pkg::ADDR_W-1:0] csr_data
);

   bfasa_pkg::dp_cmd_type  cmd;
   bfasa_pkg::dp_stat_type stat;

   // a request offered in the same cycle takes precedence over a csr write
   assign csr_ready = !busy && !start;

   bfasa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   bfasa_dpath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_wr    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== hdl/bfasa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bfasa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      // read data holds until the next read
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== hdl/bfasa_ctrl.sv =====
// Controller state machine of the segment allocator.
`default_nettype none

module bfasa_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire bfasa_pkg::dp_stat_type stat,
   output logic                       busy,
   output bfasa_pkg::dp_cmd_type      cmd
);

   bfasa_pkg::fsm_state_type state_ff;
   bfasa_pkg::fsm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfasa_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != bfasa_pkg::ST_IDLE);

   // next state and datapath command
   always_comb begin
      state_in   = state_ff;
      cmd.op     = bfasa_pkg::DP_NOP;
      cmd.code   = bfasa_pkg::RS_OK;
      cmd.hit    = 1'b0;
      cmd.grant  = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         bfasa_pkg::ST_INIT: begin
            cmd.op   = bfasa_pkg::DP_INIT;
            state_in = bfasa_pkg::ST_IDLE;
         end
         bfasa_pkg::ST_IDLE: begin
            if (stat.pool_wr) begin
               state_in = bfasa_pkg::ST_INIT;
            end else if (start) begin
               cmd.op   = bfasa_pkg::DP_LOAD;
               state_in = bfasa_pkg::ST_DISPATCH;
            end
         end
         bfasa_pkg::ST_DISPATCH: begin
            unique case (stat.act) inside
               bfasa_pkg::ACT_ALLOC: begin
                  if (stat.size_zero) begin
                     cmd.op   = bfasa_pkg::DP_RESP;
                     cmd.code = bfasa_pkg::RS_NOFIT;
                     state_in = bfasa_pkg::ST_IDLE;
                  end else begin
                     state_in = bfasa_pkg::ST_SCAN;
                  end
               end
               bfasa_pkg::ACT_FREE, bfasa_pkg::ACT_QUERY: begin
                  state_in = bfasa_pkg::ST_SCAN;
               end
               default: begin
                  cmd.op   = bfasa_pkg::DP_RESP;
                  state_in = bfasa_pkg::ST_IDLE;
               end
            endcase
         end
         bfasa_pkg::ST_SCAN: begin
            if (stat.idx_end) begin
               state_in = bfasa_pkg::ST_SCAN_END;
            end else begin
               cmd.op   = bfasa_pkg::DP_READ;
               state_in = bfasa_pkg::ST_LOOK;
            end
         end
         bfasa_pkg::ST_LOOK: begin
            if (stat.act == bfasa_pkg::ACT_ALLOC) begin
               if (stat.cur_used) begin
                  cmd.op   = bfasa_pkg::DP_NEXT;
                  state_in = bfasa_pkg::ST_SCAN;
               end else begin
                  cmd.op   = bfasa_pkg::DP_DIV_START;
                  state_in = bfasa_pkg::ST_DIV;
               end
            end else if (stat.cur_match) begin
               if (stat.act == bfasa_pkg::ACT_FREE) begin
                  cmd.op   = bfasa_pkg::DP_MATCH;
                  state_in = bfasa_pkg::ST_FREE_RD;
               end else begin
                  cmd.op   = bfasa_pkg::DP_RESP;
                  cmd.hit  = 1'b1;
                  state_in = bfasa_pkg::ST_IDLE;
               end
            end else begin
               cmd.op   = bfasa_pkg::DP_NEXT;
               state_in = bfasa_pkg::ST_SCAN;
            end
         end
         bfasa_pkg::ST_DIV: begin
            if (stat.div_busy) begin
               cmd.op = bfasa_pkg::DP_DIV_STEP;
            end else begin
               cmd.op   = bfasa_pkg::DP_EVAL;
               state_in = bfasa_pkg::ST_SCAN;
            end
         end
         bfasa_pkg::ST_SCAN_END: begin
            state_in = bfasa_pkg::ST_IDLE;
            cmd.op   = bfasa_pkg::DP_RESP;
            if (stat.act == bfasa_pkg::ACT_ALLOC) begin
               if (!stat.best_valid) begin
                  cmd.code = bfasa_pkg::RS_NOFIT;
               end else if (stat.need_over) begin
                  cmd.code = bfasa_pkg::RS_FULL;
               end else begin
                  cmd.op   = bfasa_pkg::DP_PLAN_ALLOC;
                  state_in = bfasa_pkg::ST_SH_RD;
               end
            end else if (stat.act == bfasa_pkg::ACT_FREE) begin
               cmd.code = bfasa_pkg::RS_NOTALLOC;
            end
         end
         bfasa_pkg::ST_FREE_RD: begin
            // fetch the right neighbor when there is one
            if (!stat.idx_end) begin
               cmd.op = bfasa_pkg::DP_READ;
            end
            state_in = bfasa_pkg::ST_FREE_PLAN;
         end
         bfasa_pkg::ST_FREE_PLAN: begin
            cmd.op   = bfasa_pkg::DP_PLAN_FREE;
            state_in = bfasa_pkg::ST_FREE_WR;
         end
         bfasa_pkg::ST_FREE_WR: begin
            cmd.op   = bfasa_pkg::DP_WR_MERGE;
            state_in = bfasa_pkg::ST_SH_RD;
         end
         bfasa_pkg::ST_SH_RD: begin
            if (!stat.sh_done) begin
               cmd.op   = bfasa_pkg::DP_SH_READ;
               state_in = bfasa_pkg::ST_SH_WR;
            end else if (stat.act == bfasa_pkg::ACT_ALLOC) begin
               state_in = bfasa_pkg::ST_WR_SKIP;
            end else begin
               cmd.op     = bfasa_pkg::DP_RESP;
               cmd.commit = 1'b1;
               state_in   = bfasa_pkg::ST_IDLE;
            end
         end
         bfasa_pkg::ST_SH_WR: begin
            cmd.op   = bfasa_pkg::DP_SH_WRITE;
            state_in = bfasa_pkg::ST_SH_RD;
         end
         bfasa_pkg::ST_WR_SKIP: begin
            if (stat.has_skip) begin
               cmd.op = bfasa_pkg::DP_WR_SKIP;
            end
            state_in = bfasa_pkg::ST_WR_USED;
         end
         bfasa_pkg::ST_WR_USED: begin
            cmd.op   = bfasa_pkg::DP_WR_USED;
            state_in = bfasa_pkg::ST_WR_REM;
         end
         bfasa_pkg::ST_WR_REM: begin
            if (stat.has_rem) begin
               cmd.op = bfasa_pkg::DP_WR_REM;
            end
            state_in = bfasa_pkg::ST_ALLOC_DONE;
         end
         bfasa_pkg::ST_ALLOC_DONE: begin
            cmd.op     = bfasa_pkg::DP_RESP;
            cmd.grant  = 1'b1;
            cmd.commit = 1'b1;
            state_in   = bfasa_pkg::ST_IDLE;
         end
         default: begin
            state_in = bfasa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/bfasa_dpath.sv =====
// Datapath of the segment allocator: table RAM, remainder unit, best-fit and merge logic.
`default_nettype none

module bfasa_dpath #(
   parameter int MAX_SEGMENTS = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bfasa_pkg::dp_cmd_type      cmd,
   input  wire bfasa_pkg::req_type         req_data,
   input  wire logic                       csr_wr,
   input  wire bfasa_pkg::csr_index_type   csr_index,
   input  wire logic [bfasa_pkg::ADDR_W-1:0] csr_data,
   output bfasa_pkg::dp_stat_type          stat,
   output logic                            rsp_valid,
   output bfasa_pkg::rsp_type              rsp_data
);

   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int AW    = bfasa_pkg::ADDR_W;
   localparam int LW    = bfasa_pkg::ALIGN_W;
   localparam int DIV_CNT_LOC = bfasa_pkg::DIV_CNT_W;

   // configuration and control registers
   logic [AW-1:0]     pool_ff, pool_in;
   logic [LW-1:0]     align_ff, align_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  count_new_ff, count_new_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              best_valid_ff, best_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIV_CNT_LOC-1:0] div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]  sh_cnt_ff, sh_cnt_in;
   logic              sh_down_ff, sh_down_in;

   // payload registers
   bfasa_pkg::req_type   req_ff, req_in;
   bfasa_pkg::entry_type prev_ff, prev_in;
   bfasa_pkg::entry_type hit_ff, hit_in;
   bfasa_pkg::entry_type mrg_ff, mrg_in;
   bfasa_pkg::rsp_type   rsp_ff, rsp_in;
   logic [IDX_W-1:0]     hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [AW-1:0]        best_s_ff, best_s_in;
   logic [AW-1:0]        best_len_ff, best_len_in;
   logic [LW-1:0]        best_skip_ff, best_skip_in;
   logic [AW-1:0]        best_span_ff, best_span_in;
   logic [bfasa_pkg::DIV_W-1:0] div_q_ff, div_q_in;
   logic [LW-1:0]        div_r_ff, div_r_in;
   logic [IDX_W-1:0]     sh_src_ff, sh_src_in;
   logic [IDX_W-1:0]     sh_dst_ff, sh_dst_in;
   logic [IDX_W-1:0]     wr_ptr_ff, wr_ptr_in;

   // RAM port signals
   logic                 ram_we, ram_re;
   logic [IDX_W-1:0]     ram_waddr, ram_raddr;
   bfasa_pkg::entry_type ram_wdata, cur;

   // derived values
   logic [LW-1:0]    a_eff;
   logic [LW-1:0]    skip;
   logic [AW-1:0]    span;
   logic             fits;
   logic [AW-1:0]    grant;
   logic [AW-1:0]    rem_len;
   logic             has_skip, has_rem;
   logic [CNT_W-1:0] dshift;
   logic [CNT_W:0]   need;
   logic [LW-1:0]    div_r_step;
   logic             pf, nf;
   logic [CNT_W-1:0] fr_src, fr_r;

   bfasa_ram #(
      .WIDTH ($bits(bfasa_pkg::entry_type)),
      .DEPTH (MAX_SEGMENTS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (cur)
   );

   // zero alignment behaves as one
   assign a_eff = (align_ff == '0) ? LW'(1) : align_ff;

   // remainder unit: four restoring steps per cycle
   always_comb begin
      logic [LW:0] r_v;
      r_v = {1'b0, div_r_ff};
      for (int j = 0; j < bfasa_pkg::DIV_BITS; j++) begin
         r_v = {r_v[LW-1:0], div_q_ff[bfasa_pkg::DIV_W-1-j]};
         if (r_v >= {1'b0, a_eff}) begin
            r_v = r_v - {1'b0, a_eff};
         end
      end
      div_r_step = r_v[LW-1:0];
   end

   // candidate check for the entry just divided
   assign skip = (div_r_ff == '0) ? '0 : (a_eff - div_r_ff);
   assign span = cur.length - AW'(skip);
   assign fits = (AW'(skip) <= cur.length) && (req_ff.request_size <= span);

   // carve plan for the best segment
   assign grant    = best_s_ff + AW'(best_skip_ff);
   assign rem_len  = best_len_ff - AW'(best_skip_ff) - req_ff.request_size;
   assign has_skip = (best_skip_ff != '0);
   assign has_rem  = (rem_len != '0);
   assign dshift   = CNT_W'(has_skip) + CNT_W'(has_rem);
   assign need     = (CNT_W+1)'(count_ff) + (CNT_W+1)'(dshift);

   // merge plan for a free
   assign pf     = (hit_idx_ff != '0) && !prev_ff.used;
   assign nf     = (idx_ff < count_ff) && !cur.used;
   assign fr_r   = CNT_W'(pf) + CNT_W'(nf);
   assign fr_src = CNT_W'(hit_idx_ff) + CNT_W'(1) + CNT_W'(nf);

   // status to the controller
   always_comb begin
      stat.act        = req_ff.action;
      stat.size_zero  = (req_ff.request_size == '0);
      stat.idx_end    = (idx_ff == count_ff);
      stat.cur_used   = cur.used;
      stat.cur_match  = cur.used && (cur.start == req_ff.address);
      stat.div_busy   = (div_cnt_ff != '0);
      stat.best_valid = best_valid_ff;
      stat.need_over  = (need > (CNT_W+1)'(MAX_SEGMENTS));
      stat.has_skip   = has_skip;
      stat.has_rem    = has_rem;
      stat.sh_done    = (sh_cnt_ff == '0);
      stat.pool_wr    = csr_wr && (csr_index == bfasa_pkg::CSR_POOL);
   end

   // command decode
   always_comb begin
      pool_in       = pool_ff;
      align_in      = align_ff;
      count_in      = count_ff;
      count_new_in  = count_new_ff;
      idx_in        = idx_ff;
      best_valid_in = best_valid_ff;
      rsp_valid_in  = 1'b0;
      div_cnt_in    = div_cnt_ff;
      sh_cnt_in     = sh_cnt_ff;
      sh_down_in    = sh_down_ff;
      req_in        = req_ff;
      prev_in       = prev_ff;
      hit_in        = hit_ff;
      mrg_in        = mrg_ff;
      rsp_in        = rsp_ff;
      hit_idx_in    = hit_idx_ff;
      best_idx_in   = best_idx_ff;
      best_s_in     = best_s_ff;
      best_len_in   = best_len_ff;
      best_skip_in  = best_skip_ff;
      best_span_in  = best_span_ff;
      div_q_in      = div_q_ff;
      div_r_in      = div_r_ff;
      sh_src_in     = sh_src_ff;
      sh_dst_in     = sh_dst_ff;
      wr_ptr_in     = wr_ptr_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = wr_ptr_ff;
      ram_raddr     = IDX_W'(idx_ff);
      ram_wdata     = cur;

      if (csr_wr) begin
         if (csr_index == bfasa_pkg::CSR_POOL) begin
            pool_in = csr_data;
         end else begin
            align_in = csr_data[LW-1:0];
         end
      end

      unique case (cmd.op)
         bfasa_pkg::DP_INIT: begin
            ram_we       = 1'b1;
            ram_waddr    = '0;
            ram_wdata    = '{start: bfasa_pkg::POOL_BASE, length: pool_ff, used: 1'b0};
            count_in     = CNT_W'(1);
         end
         bfasa_pkg::DP_LOAD: begin
            req_in        = req_data;
            idx_in        = '0;
            best_valid_in = 1'b0;
         end
         bfasa_pkg::DP_READ: begin
            ram_re = 1'b1;
         end
         bfasa_pkg::DP_NEXT: begin
            prev_in = cur;
            idx_in  = idx_ff + CNT_W'(1);
         end
         bfasa_pkg::DP_DIV_START: begin
            div_q_in   = bfasa_pkg::DIV_W'(cur.start);
            div_r_in   = '0;
            div_cnt_in = DIV_CNT_LOC'(bfasa_pkg::DIV_STEPS);
         end
         bfasa_pkg::DP_DIV_STEP: begin
            div_q_in   = div_q_ff << bfasa_pkg::DIV_BITS;
            div_r_in   = div_r_step;
            div_cnt_in = div_cnt_ff - DIV_CNT_LOC'(1);
         end
         bfasa_pkg::DP_EVAL: begin
            // smallest usable span wins, first one on a tie
            if (fits && (!best_valid_ff || (span < best_span_ff))) begin
               best_valid_in = 1'b1;
               best_idx_in   = IDX_W'(idx_ff);
               best_s_in     = cur.start;
               best_len_in   = cur.length;
               best_skip_in  = skip;
               best_span_in  = span;
            end
            prev_in = cur;
            idx_in  = idx_ff + CNT_W'(1);
         end
         bfasa_pkg::DP_MATCH: begin
            hit_idx_in = IDX_W'(idx_ff);
            hit_in     = cur;
            idx_in     = idx_ff + CNT_W'(1);
         end
         bfasa_pkg::DP_PLAN_ALLOC: begin
            // entries above the best one move up by the number of extra rows
            sh_src_in    = IDX_W'(count_ff - CNT_W'(1));
            sh_dst_in    = IDX_W'(count_ff - CNT_W'(1) + dshift);
            sh_cnt_in    = (dshift == '0) ? '0
                         : (count_ff - CNT_W'(1) - CNT_W'(best_idx_ff));
            sh_down_in   = 1'b1;
            wr_ptr_in    = best_idx_ff;
            count_new_in = count_ff + dshift;
         end
         bfasa_pkg::DP_PLAN_FREE: begin
            mrg_in.start  = pf ? prev_ff.start : hit_ff.start;
            mrg_in.length = (pf ? prev_ff.length : '0) + hit_ff.length
                          + (nf ? cur.length : '0);
            mrg_in.used   = 1'b0;
            wr_ptr_in     = hit_idx_ff - IDX_W'(pf);
            sh_src_in     = IDX_W'(fr_src);
            sh_dst_in     = IDX_W'(fr_src - fr_r);
            sh_cnt_in     = count_ff - fr_src;
            sh_down_in    = 1'b0;
            count_new_in  = count_ff - fr_r;
         end
         bfasa_pkg::DP_SH_READ: begin
            ram_re    = 1'b1;
            ram_raddr = sh_src_ff;
         end
         bfasa_pkg::DP_SH_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = sh_dst_ff;
            ram_wdata = cur;
            sh_cnt_in = sh_cnt_ff - CNT_W'(1);
            if (sh_down_ff) begin
               sh_src_in = sh_src_ff - IDX_W'(1);
               sh_dst_in = sh_dst_ff - IDX_W'(1);
            end else begin
               sh_src_in = sh_src_ff + IDX_W'(1);
               sh_dst_in = sh_dst_ff + IDX_W'(1);
            end
         end
         bfasa_pkg::DP_WR_SKIP: begin
            ram_we    = 1'b1;
            ram_wdata = '{start: best_s_ff, length: AW'(best_skip_ff), used: 1'b0};
            wr_ptr_in = wr_ptr_ff + IDX_W'(1);
         end
         bfasa_pkg::DP_WR_USED: begin
            ram_we    = 1'b1;
            ram_wdata = '{start: grant, length: req_ff.request_size, used: 1'b1};
            wr_ptr_in = wr_ptr_ff + IDX_W'(1);
         end
         bfasa_pkg::DP_WR_REM: begin
            ram_we    = 1'b1;
            ram_wdata = '{start: grant + req_ff.request_size, length: rem_len, used: 1'b0};
            wr_ptr_in = wr_ptr_ff + IDX_W'(1);
         end
         bfasa_pkg::DP_WR_MERGE: begin
            ram_we    = 1'b1;
            ram_wdata = mrg_ff;
         end
         bfasa_pkg::DP_RESP: begin
            rsp_valid_in           = 1'b1;
            rsp_in.status          = cmd.code;
            rsp_in.granted_address = cmd.grant ? grant : '0;
            rsp_in.is_allocated    = cmd.hit;
            if (cmd.commit) begin
               count_in = count_new_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff       <= bfasa_pkg::POOL_RESET;
         align_ff      <= bfasa_pkg::ALIGN_RESET;
         count_ff      <= CNT_W'(1);
         idx_ff        <= '0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         div_cnt_ff    <= '0;
         sh_cnt_ff     <= '0;
         sh_down_ff    <= 1'b0;
         count_new_ff  <= CNT_W'(1);
      end else begin
         pool_ff       <= pool_in;
         align_ff      <= align_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         best_valid_ff <= best_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         div_cnt_ff    <= div_cnt_in;
         sh_cnt_ff     <= sh_cnt_in;
         sh_down_ff    <= sh_down_in;
         count_new_ff  <= count_new_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      prev_ff      <= prev_in;
      hit_ff       <= hit_in;
      mrg_ff       <= mrg_in;
      rsp_ff       <= rsp_in;
      hit_idx_ff   <= hit_idx_in;
      best_idx_ff  <= best_idx_in;
      best_s_ff    <= best_s_in;
      best_len_ff  <= best_len_in;
      best_skip_ff <= best_skip_in;
      best_span_ff <= best_span_in;
      div_q_ff     <= div_q_in;
      div_r_ff     <= div_r_in;
      sh_src_ff    <= sh_src_in;
      sh_dst_ff    <= sh_dst_in;
      wr_ptr_ff    <= wr_ptr_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/bfasa_checker.sv =====
// Port-level checker for the segment allocator and its bind.
`default_nettype none

module bfasa_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire bfasa_pkg::rsp_type rsp_data
);

   // an accepted request keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   // a response marks the return to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // one response per request, never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back responses");

   a_fail_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != bfasa_pkg::RS_OK)
      |-> (rsp_data.granted_address == '0) && !rsp_data.is_allocated)
      else $error("failed request carries a grant");

endmodule

bind best_fit_aligned_segment_allocator bfasa_checker u_bfasa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== test/best_fit_aligned_segment_allocator_tb.sv =====
// Self-checking testbench for the best-fit aligned segment allocator.
`default_nettype none

module best_fit_aligned_segment_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SEGS = 64;
   localparam longint unsigned MASK35 = (64'd1 << 35) - 1;

   // Segment table mirror with the expected response queue
   class alloc_scoreboard;
      logic [63:0] seg_base[SEGS];
      logic [63:0] seg_len[SEGS];
      bit          seg_busy[SEGS];
      int          seg_cnt;
      logic [63:0] pool;
      logic [63:0] align;
      bfasa_pkg::rsp_type expected_q[$];
      logic [63:0] live_q[$];
      int          errors;
      int          n_ok_alloc, n_nofit, n_full, n_freed, n_notalloc, n_hits;

      function new();
         errors = 0;
         pool   = 64'd17179869184;
         align  = 64'd1;
         rebuild();
      endfunction

      function void rebuild();
         for (int k = 0; k < SEGS; k++) begin
            seg_base[k] = 0;
            seg_len[k]  = 0;
            seg_busy[k] = 0;
         end
         seg_base[0] = 1;
         seg_len[0]  = pool;
         seg_cnt     = 1;
         live_q.delete();
      endfunction

      function void write_csr(bfasa_pkg::csr_index_type idx,
                              logic [bfasa_pkg::ADDR_W-1:0] value);
         if (idx == bfasa_pkg::CSR_POOL) begin
            pool = 64'(value);
            rebuild();
         end else begin
            align = 64'(value) & 64'h1FFF;
         end
      endfunction

      function void drop_row(int i);
         if (i >= seg_cnt) return;
         for (int k = i; k + 1 < seg_cnt; k++) begin
            seg_base[k] = seg_base[k+1];
            seg_len[k]  = seg_len[k+1];
            seg_busy[k] = seg_busy[k+1];
         end
         seg_cnt--;
         seg_base[seg_cnt] = 0;
         seg_len[seg_cnt]  = 0;
         seg_busy[seg_cnt] = 0;
      endfunction

      function void add_row(int i, logic [63:0] s, logic [63:0] len, bit u);
         if (seg_cnt >= SEGS || i > seg_cnt) return;
         for (int k = seg_cnt; k > i; k--) begin
            seg_base[k] = seg_base[k-1];
            seg_len[k]  = seg_len[k-1];
            seg_busy[k] = seg_busy[k-1];
         end
         seg_base[i] = s;
         seg_len[i]  = len;
         seg_busy[i] = u;
         seg_cnt++;
      endfunction

      function logic [63:0] skip_for(logic [63:0] s, logic [63:0] a);
         logic [63:0] r;
         r = s % a;
         return (r != 0) ? a - r : 0;
      endfunction

      function bfasa_pkg::rsp_type do_alloc(logic [63:0] size);
         bfasa_pkg::rsp_type r;
         logic [63:0] a, best_span, skip, len, rem, grant, s;
         int          best, need, i;
         r = '0;
         a = (align != 0) ? align : 64'd1;
         best = -1;
         best_span = 0;
         if (size == 0) begin
            r.status = bfasa_pkg::RS_NOFIT;
            return r;
         end
         for (int k = 0; k < seg_cnt; k++) begin
            if (seg_busy[k]) continue;
            skip = skip_for(seg_base[k], a);
            len  = seg_len[k];
            if (skip > len || size > len - skip) continue;
            if (best < 0 || len - skip < best_span) begin
               best = k;
               best_span = len - skip;
            end
         end
         if (best < 0) begin
            r.status = bfasa_pkg::RS_NOFIT;
            return r;
         end
         i    = best;
         s    = seg_base[i];
         len  = seg_len[i];
         skip = skip_for(s, a);
         rem  = len - skip - size;
         need = seg_cnt + (skip != 0) + (rem != 0);
         if (need > SEGS) begin
            r.status = bfasa_pkg::RS_FULL;
            return r;
         end
         grant = s + skip;
         drop_row(i);
         if (rem != 0) add_row(i, grant + size, rem, 0);
         add_row(i, grant, size, 1);
         if (skip != 0) add_row(i, s, skip, 0);
         r.status = bfasa_pkg::RS_OK;
         r.granted_address = grant[bfasa_pkg::ADDR_W-1:0];
         live_q.push_back(grant);
         return r;
      endfunction

      function bfasa_pkg::rsp_type do_free(logic [63:0] addr);
         bfasa_pkg::rsp_type r;
         r = '0;
         for (int i = 0; i < seg_cnt; i++) begin
            if (!seg_busy[i] || seg_base[i] != addr) continue;
            if (i + 1 < seg_cnt && !seg_busy[i+1]) begin
               seg_len[i] = seg_len[i] + seg_len[i+1];
               drop_row(i + 1);
            end
            seg_busy[i] = 0;
            if (i > 0 && !seg_busy[i-1]) begin
               seg_len[i-1] = seg_len[i-1] + seg_len[i];
               drop_row(i);
            end
            foreach (live_q[k])
               if (live_q[k] == addr) begin
                  live_q.delete(k);
                  break;
               end
            r.status = bfasa_pkg::RS_OK;
            return r;
         end
         r.status = bfasa_pkg::RS_NOTALLOC;
         return r;
      endfunction

      // Accepted request: predict its response
      function void note(bfasa_pkg::req_type rq);
         bfasa_pkg::rsp_type r;
         r = '0;
         case (rq.action)
            bfasa_pkg::ACT_ALLOC: begin
               r = do_alloc(64'(rq.request_size));
               if (r.status == bfasa_pkg::RS_OK) n_ok_alloc++;
               else if (r.status == bfasa_pkg::RS_FULL) n_full++;
               else n_nofit++;
            end
            bfasa_pkg::ACT_FREE: begin
               r = do_free(64'(rq.address));
               if (r.status == bfasa_pkg::RS_OK) n_freed++;
               else n_notalloc++;
            end
            bfasa_pkg::ACT_QUERY: begin
               for (int i = 0; i < seg_cnt; i++)
                  if (seg_busy[i] && seg_base[i] == 64'(rq.address)) begin
                     r.is_allocated = 1'b1;
                     break;
                  end
               if (r.is_allocated) n_hits++;
            end
            default: ;
         endcase
         expected_q.push_back(r);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         errors++;
      endtask

      // Response seen on the port: compare with the oldest prediction
      task check(bfasa_pkg::rsp_type got);
         bfasa_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.granted_address !== want.granted_address)
            report($sformatf("granted_address %0d, expected %0d",
                             got.granted_address, want.granted_address));
         if (got.is_allocated !== want.is_allocated)
            report($sformatf("is_allocated %0b, expected %0b",
                             got.is_allocated, want.is_allocated));
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   bfasa_pkg::req_type            req_data;
   logic                          rsp_valid;
   bfasa_pkg::rsp_type            rsp_data;
   logic                          csr_valid;
   logic                          csr_ready;
   bfasa_pkg::csr_index_type      csr_index;
   logic [bfasa_pkg::ADDR_W-1:0]  csr_data;

   alloc_scoreboard sb;
   int              item_no;

   best_fit_aligned_segment_allocator DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Watch both handshakes at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note(req_data);
         if (rsp_valid) sb.check(rsp_data);
      end
   end

   // One request: optional idle gap, then hold start until taken
   task automatic send(bfasa_pkg::action_type act, logic [63:0] size, logic [63:0] addr);
      int gap;
      gap = 0;
      if ((item_no < 150 || item_no > 230) && $urandom_range(0, 99) < 24)
         gap = $urandom_range(1, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= '{action: act,
                    request_size: size[bfasa_pkg::ADDR_W-1:0],
                    address: addr[bfasa_pkg::ADDR_W-1:0]};
      do @(posedge clock); while (busy);
      item_no++;
   endtask

   // Drain outstanding responses, then settle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(bfasa_pkg::csr_index_type idx, logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[bfasa_pkg::ADDR_W-1:0];
      do @(posedge clock); while (!csr_ready);
      sb.write_csr(idx, value[bfasa_pkg::ADDR_W-1:0]);
      csr_valid <= 1'b0;
      repeat (2) @(posedge clock);
   endtask

   function automatic logic [63:0] rand35();
      logic [63:0] w;
      logic [34:0] v;
      w = {$urandom(), $urandom()};
      v = w[34:0];
      return 64'(v);
   endfunction

   // Random mix: mostly allocations of modest size and frees of live blocks
   task automatic random_phase(logic [63:0] pool, logic [63:0] align, int n,
                               logic [63:0] size_cap);
      int          pick;
      logic [63:0] sz, ad;
      drain();
      csr_write(bfasa_pkg::CSR_POOL, pool);
      csr_write(bfasa_pkg::CSR_ALIGN, align);
      for (int j = 0; j < n; j++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 19) == 0) sz = rand35();
            else sz = 64'd1 + ({$urandom(), $urandom()} % size_cap);
            send(bfasa_pkg::ACT_ALLOC, sz, rand35());
         end else if (pick < 80 && sb.live_q.size() > 0) begin
            ad = sb.live_q[$urandom_range(0, sb.live_q.size() - 1)];
            send(bfasa_pkg::ACT_FREE, rand35(), ad);
         end else if (pick < 92) begin
            if (sb.live_q.size() > 0 && $urandom_range(0, 1))
               ad = sb.live_q[$urandom_range(0, sb.live_q.size() - 1)];
            else
               ad = rand35();
            send(bfasa_pkg::ACT_QUERY, rand35(), ad);
         end else if (pick < 97) begin
            send(bfasa_pkg::ACT_FREE, rand35(), rand35());
         end else begin
            send(bfasa_pkg::ACT_NONE, rand35(), rand35());
         end
      end
   endtask

   initial begin
      sb        = new();
      item_no   = 0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = bfasa_pkg::CSR_POOL;
      csr_data  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed requests on the reset pool
      send(bfasa_pkg::ACT_QUERY, 0, 0);
      send(bfasa_pkg::ACT_FREE, 0, 0);
      send(bfasa_pkg::ACT_ALLOC, 0, 0);
      send(bfasa_pkg::ACT_ALLOC, MASK35, MASK35);
      send(bfasa_pkg::ACT_ALLOC, 64'd17179869184, 0);
      send(bfasa_pkg::ACT_QUERY, 0, 1);
      send(bfasa_pkg::ACT_ALLOC, 1, 0);
      send(bfasa_pkg::ACT_FREE, 0, 1);
      send(bfasa_pkg::ACT_ALLOC, 1, 0);
      send(bfasa_pkg::ACT_ALLOC, 10, 0);
      send(bfasa_pkg::ACT_QUERY, 0, 2);
      send(bfasa_pkg::ACT_FREE, 0, 3);
      send(bfasa_pkg::ACT_FREE, 0, 2);
      send(bfasa_pkg::ACT_FREE, 0, 1);
      send(bfasa_pkg::ACT_NONE, MASK35, MASK35);
      drain();
      csr_write(bfasa_pkg::CSR_ALIGN, 4096);
      send(bfasa_pkg::ACT_ALLOC, 5, 0);
      send(bfasa_pkg::ACT_ALLOC, 100, 0);
      send(bfasa_pkg::ACT_FREE, 0, 4096);
      send(bfasa_pkg::ACT_ALLOC, 4095, 0);
      drain();
      // Empty pool and zero alignment
      csr_write(bfasa_pkg::CSR_POOL, 0);
      csr_write(bfasa_pkg::CSR_ALIGN, 0);
      send(bfasa_pkg::ACT_ALLOC, 1, 0);
      send(bfasa_pkg::ACT_QUERY, 0, 1);
      send(bfasa_pkg::ACT_FREE, 0, 1);

      random_phase(MASK35, 4096, 80, 64'd1 << 30);
      random_phase(300, 7, 120, 6);
      random_phase(1000, 1, 90, 40);
      random_phase(20000, 8191, 60, 3000);
      random_phase(64'd17179869184, 1, 80, 64'd1 << 20);

      drain();
      repeat (20) @(posedge clock);
      $display("Ran %0d requests: %0d grants, %0d no-fit, %0d table-full,",
               item_no, sb.n_ok_alloc, sb.n_nofit, sb.n_full);
      $display("%0d frees, %0d bad frees, %0d query hits.",
               sb.n_freed, sb.n_notalloc, sb.n_hits);
      if (sb.expected_q.size() != 0)
         sb.report("responses still outstanding at end of run");
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #20000000;
      $display("Timeout: run did not complete");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
